>>> design/dwms_pkg.sv
package dwms_pkg;

  localparam int OUT_SUM_W = 19;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_POP,
    ST_HOLD,
    ST_DRAIN_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] window_sum;
    logic [OUT_SUM_W-1:0] best_sum;
    logic                 is_last;
  } res_t;

endpackage

>>> design/dwms_ram.sv
module dwms_ram #(
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/dwms_ctrl.sv
module dwms_ctrl #(
  parameter int VALUE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_last,
  output logic                  mark_we,
  output logic [VALUE_BITS-1:0] mark_waddr,
  output logic                  mark_wdata,
  output logic [VALUE_BITS-1:0] mark_raddr,
  input  logic                  mark_q,
  output logic                  ring_we,
  output logic [VALUE_BITS-1:0] ring_waddr,
  output logic [VALUE_BITS-1:0] ring_wdata,
  output logic [VALUE_BITS-1:0] ring_raddr,
  input  logic [VALUE_BITS-1:0] ring_q,
  output logic                  res_valid,
  output dwms_pkg::res_t        res,
  input  logic                  res_ready
);

  localparam int AW = VALUE_BITS;
  localparam int SW = 2 * VALUE_BITS;

  dwms_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic [AW:0]      len_r, len_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [SW-1:0]    best_r, best_nxt;
  logic [AW-1:0]    v_r, v_nxt;
  logic             last_r, last_nxt;

  logic          do_pop;
  logic          pop_hit;
  logic [SW-1:0] app_sum;
  dwms_pkg::state_t done_state;

  assign do_pop     = mark_q && (len_r != '0);
  assign pop_hit    = (ring_q == v_r);
  assign app_sum    = sum_r + SW'(v_r);
  assign in_stall   = (state_r != dwms_pkg::ST_IDLE);
  assign mark_raddr = in_value;
  assign ring_raddr = oldest_nxt;

  always_comb begin
    if (!res_ready) begin
      done_state = dwms_pkg::ST_HOLD;
    end else if (last_r) begin
      done_state = dwms_pkg::ST_DRAIN_ISSUE;
    end else begin
      done_state = dwms_pkg::ST_IDLE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwms_pkg::ST_CLEAR: begin
        if (&clr_r) begin
          state_nxt = dwms_pkg::ST_IDLE;
        end
      end
      dwms_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dwms_pkg::ST_CHECK;
        end
      end
      dwms_pkg::ST_CHECK: begin
        state_nxt = do_pop ? dwms_pkg::ST_POP : done_state;
      end
      dwms_pkg::ST_POP: begin
        if (pop_hit) begin
          state_nxt = done_state;
        end
      end
      dwms_pkg::ST_HOLD: begin
        if (res_ready) begin
          state_nxt = last_r ? dwms_pkg::ST_DRAIN_ISSUE : dwms_pkg::ST_IDLE;
        end
      end
      dwms_pkg::ST_DRAIN_ISSUE: begin
        state_nxt = dwms_pkg::ST_DRAIN;
      end
      dwms_pkg::ST_DRAIN: begin
        if (len_r == (AW+1)'(1)) begin
          state_nxt = dwms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dwms_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    oldest_nxt = oldest_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    best_nxt   = best_r;
    v_nxt      = v_r;
    last_nxt   = last_r;
    mark_we    = 1'b0;
    mark_waddr = v_r;
    mark_wdata = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = oldest_r + len_r[AW-1:0];
    ring_wdata = v_r;
    res_valid  = 1'b0;
    case (state_r)
      dwms_pkg::ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
      end
      dwms_pkg::ST_IDLE: begin
        if (in_valid) begin
          v_nxt    = in_value;
          last_nxt = in_last;
        end
      end
      dwms_pkg::ST_CHECK: begin
        if (!do_pop) begin
          ring_we    = 1'b1;
          mark_we    = 1'b1;
          mark_wdata = 1'b1;
          len_nxt    = len_r + 1'b1;
          sum_nxt    = app_sum;
          best_nxt   = (app_sum > best_r) ? app_sum : best_r;
          res_valid  = 1'b1;
        end
      end
      dwms_pkg::ST_POP: begin
        oldest_nxt = oldest_r + 1'b1;
        if (pop_hit) begin
          // earlier copy leaves, new copy enters: mark and sum unchanged
          ring_we   = 1'b1;
          res_valid = 1'b1;
        end else begin
          mark_we    = 1'b1;
          mark_waddr = ring_q;
          sum_nxt    = sum_r - SW'(ring_q);
          len_nxt    = len_r - 1'b1;
        end
      end
      dwms_pkg::ST_HOLD: begin
        res_valid = 1'b1;
      end
      dwms_pkg::ST_DRAIN_ISSUE: begin
      end
      dwms_pkg::ST_DRAIN: begin
        mark_we    = 1'b1;
        mark_waddr = ring_q;
        oldest_nxt = oldest_r + 1'b1;
        len_nxt    = len_r - 1'b1;
        if (len_r == (AW+1)'(1)) begin
          oldest_nxt = '0;
          sum_nxt    = '0;
          best_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
    res.window_sum = dwms_pkg::OUT_SUM_W'(sum_nxt);
    res.best_sum   = dwms_pkg::OUT_SUM_W'(best_nxt);
    res.is_last    = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dwms_pkg::ST_CLEAR;
      clr_r    <= '0;
      oldest_r <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      best_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      oldest_r <= oldest_nxt;
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      best_r   <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    last_r <= last_nxt;
  end

endmodule

>>> design/distinct_window_max_sum.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_value, in_last
// out_     output     out_valid/ out_stall out_window_sum, out_best_sum, out_is_last
//
// An item is taken in IDLE and looked up in CHECK, then POP removes values from the window's oldest end;
// the single read port of the ring memory sets the pop rate at one value per cycle.
// After the final element, the DRAIN_ISSUE and DRAIN states clear the presence marks of the window.
// After reset, the CLEAR state clears all 2**VALUE_BITS addresses of the presence memory; in_stall is high.
// A full output register holds the finished item until out_stall drops.
module distinct_window_max_sum #(
  parameter int VALUE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [VALUE_BITS-1:0]          in_value,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dwms_pkg::OUT_SUM_W-1:0] out_window_sum,
  output logic [dwms_pkg::OUT_SUM_W-1:0] out_best_sum,
  output logic                           out_is_last
);

  logic                  mark_we;
  logic [VALUE_BITS-1:0] mark_waddr;
  logic                  mark_wdata;
  logic [VALUE_BITS-1:0] mark_raddr;
  logic                  mark_q;
  logic                  ring_we;
  logic [VALUE_BITS-1:0] ring_waddr;
  logic [VALUE_BITS-1:0] ring_wdata;
  logic [VALUE_BITS-1:0] ring_raddr;
  logic [VALUE_BITS-1:0] ring_q;
  logic                  res_valid;
  dwms_pkg::res_t        res;
  logic                  res_ready;
  logic                  out_valid_r, out_valid_nxt;
  dwms_pkg::res_t        out_r;

  dwms_ram #(.AW(VALUE_BITS), .DW(1)) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_q)
  );

  dwms_ram #(.AW(VALUE_BITS), .DW(VALUE_BITS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  dwms_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_last    (in_last),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_raddr (mark_raddr),
    .mark_q     (mark_q),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_raddr (ring_raddr),
    .ring_q     (ring_q),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_sum = out_r.window_sum;
  assign out_best_sum   = out_r.best_sum;
  assign out_is_last    = out_r.is_last;

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("finished transaction changed while output register full");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !res_valid)
    else $error("input transaction taken while a result is pending");

  a_best_covers_window: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (2 * VALUE_BITS - 1 <= dwms_pkg::OUT_SUM_W) |->
      res.best_sum >= res.window_sum)
    else $error("best sum below window sum");

endmodule

>>> dv/distinct_window_max_sum_tb.sv
module distinct_window_max_sum_tb;

  localparam int VALUE_BITS     = 10;
  localparam int DOMAIN         = 1 << VALUE_BITS;
  localparam int VALUE_MAX      = DOMAIN - 1;
  localparam int RANDOM_ITEMS   = 80;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES  = DOMAIN + 64;
  localparam int LONG_HOLD      = 600;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [VALUE_BITS-1:0]          in_value;
  logic                           in_last;
  logic                           out_valid;
  logic                           out_stall;
  logic [dwms_pkg::OUT_SUM_W-1:0] out_window_sum;
  logic [dwms_pkg::OUT_SUM_W-1:0] out_best_sum;
  logic                           out_is_last;

  distinct_window_max_sum #(.VALUE_BITS(VALUE_BITS)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_window_sum(out_window_sum),
    .out_best_sum  (out_best_sum),
    .out_is_last   (out_is_last)
  );

  // window model
  bit                    seen_mark [0:DOMAIN-1];
  logic [VALUE_BITS-1:0] window_mem [0:DOMAIN-1];
  int unsigned           head_ptr;
  int unsigned           window_count;
  int unsigned           window_total;
  int unsigned           best_total;
  dwms_pkg::res_t        expected_sums[$];

  int mismatch_count;
  int burst_left;
  bit sender_gapless;
  int hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void drop_oldest();
    logic [VALUE_BITS-1:0] v;
    v = window_mem[head_ptr];
    seen_mark[v] = 1'b0;
    window_total -= v;
    head_ptr = (head_ptr + 1) % DOMAIN;
    window_count--;
  endfunction

  function automatic void predict_window(logic [VALUE_BITS-1:0] v, logic l);
    dwms_pkg::res_t r;
    while (seen_mark[v] && window_count > 0) drop_oldest();
    if (window_count >= DOMAIN) drop_oldest();
    window_mem[(head_ptr + window_count) % DOMAIN] = v;
    seen_mark[v] = 1'b1;
    window_count++;
    window_total += v;
    if (window_total > best_total) best_total = window_total;
    r.window_sum = window_total[dwms_pkg::OUT_SUM_W-1:0];
    r.best_sum   = best_total[dwms_pkg::OUT_SUM_W-1:0];
    r.is_last    = l;
    expected_sums.push_back(r);
    if (l) begin
      while (window_count > 0) drop_oldest();
      head_ptr     = 0;
      window_total = 0;
      best_total   = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(int v, logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v[VALUE_BITS-1:0];
    in_last  <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_window(v[VALUE_BITS-1:0], l);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // result checker
  initial begin
    dwms_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected transaction, window_sum", int'(out_window_sum), -1);
        end else begin
          want = expected_sums.pop_front();
          if (out_window_sum !== want.window_sum)
            report_mismatch("window_sum", int'(out_window_sum), int'(want.window_sum));
          if (out_best_sum !== want.best_sum)
            report_mismatch("best_sum", int'(out_best_sum), int'(want.best_sum));
          if (out_is_last !== want.is_last)
            report_mismatch("is_last", int'(out_is_last), int'(want.is_last));
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    rx_mode_t mode;
    int seg_left;
    int hold_left;
    mode = RX_OPEN;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 200);
        end
        seg_left--;
        case (mode)
          RX_OPEN:     out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
          RX_PERIODIC: out_stall <= ((seg_left % 4) == 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  // watchdog on quiet cycles
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[distinct_window_max_sum] ERROR");
        $finish;
      end
    end
  end

  task automatic test_single_elements();
    send_item(0, 1'b1);
    send_item(VALUE_MAX, 1'b1);
    send_item(1, 1'b1);
  endtask

  task automatic test_duplicates();
    // repeat of the newest value
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b1);
    // earlier copy in the middle of the window
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(2, 1'b0);
    send_item(4, 1'b1);
    // copy at the newest end flushes the whole window; best stays above
    send_item(1000, 1'b0);
    send_item(1, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b1);
    send_item(0, 1'b0);
    send_item(VALUE_MAX, 1'b0);
    send_item(0, 1'b0);
    send_item(VALUE_MAX, 1'b1);
  endtask

  task automatic test_array_boundary();
    // marks must be gone after the final element
    send_item(7, 1'b0);
    send_item(8, 1'b0);
    send_item(9, 1'b1);
    send_item(7, 1'b0);
    send_item(8, 1'b0);
    send_item(9, 1'b1);
    drain_results();
  endtask

  task automatic test_full_domain();
    int i;
    sender_gapless = 1'b0;
    for (i = 0; i < DOMAIN; i++) send_item((i * 7) % DOMAIN, 1'b0);
    send_item(0, 1'b0);
    send_item(((DOMAIN - 1) * 7) % DOMAIN, 1'b0);
    send_item(VALUE_MAX, 1'b1);
    drain_results();
  endtask

  task automatic test_receiver_hold();
    int i;
    @(posedge clk);
    hold_request = LONG_HOLD;
    sender_gapless = 1'b1;
    for (i = 0; i < 80; i++) send_item($urandom_range(0, 15), (i % 20) == 19);
    sender_gapless = 1'b0;
    drain_results();
  endtask

  task automatic test_random_arrays();
    int sent;
    int len;
    int span;
    int base;
    int i;
    int v;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       len = $urandom_range(1, 3);
      else if (pick < 72) len = $urandom_range(4, 30);
      else if (pick < 97) len = $urandom_range(31, 150);
      else                len = $urandom_range(300, 600);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      case ($urandom_range(0, 3))
        0:       span = 4;
        1:       span = 16;
        2:       span = 64;
        default: span = DOMAIN;
      endcase
      base = $urandom_range(0, DOMAIN - span);
      sender_gapless = ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)      v = 0;
        else if (pick < 6) v = VALUE_MAX;
        else               v = base + $urandom_range(0, span - 1);
        send_item(v, i == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    sender_gapless = 1'b0;
  endtask

  initial begin
    in_valid       = 1'b0;
    in_value       = '0;
    in_last        = 1'b0;
    out_stall      = 1'b0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    sender_gapless = 1'b0;
    hold_request   = 0;
    head_ptr       = 0;
    window_count   = 0;
    window_total   = 0;
    best_total     = 0;
    for (int k = 0; k < DOMAIN; k++) begin
      seen_mark[k]  = 1'b0;
      window_mem[k] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_single_elements();
    test_duplicates();
    test_array_boundary();
    test_receiver_hold();
    test_full_domain();
    test_random_arrays();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_sums.size() != 0)
      report_mismatch("results missing at end, count", 0, expected_sums.size());
    if (mismatch_count == 0) begin
      $display("[distinct_window_max_sum] OK");
    end else begin
      $display("[distinct_window_max_sum] ERROR");
    end
    $finish;
  end

endmodule
